// ===== rtl/scc_pkg.sv =====
// Package for the spherical/cartesian converter: constants, CORDIC arctangent table,
// shared types. No dependencies.
package scc_pkg;

   localparam int ANGLE_ITERATIONS_DEF = 24;
   localparam int TAB_LEN = 32;
   localparam int AW = 36;   // internal angle width, 2^-24 degree
   localparam int VW = 36;   // CORDIC datapath width

   localparam logic signed [AW-1:0] DEG90  = 36'sd1509949440;
   localparam logic signed [AW-1:0] DEG180 = 36'sd3019898880;
   localparam logic signed [AW-1:0] DEG360 = 36'sd6039797760;
   localparam logic signed [VW-1:0] GAIN_Q30 = 36'sd652032874;
   localparam logic signed [24:0] AZ_MAX = 25'sd11796480;
   localparam logic signed [23:0] EL_MAX = 24'sd5898240;

   // Arctangent of 2^-i in 2^-24 degree
   function automatic logic signed [AW-1:0] atan_lut(input logic [4:0] idx);
      logic signed [AW-1:0] r;
      begin
         case (idx)
            5'd0: r = 36'sd754974720;  5'd1: r = 36'sd445687602;
            5'd2: r = 36'sd235489088;  5'd3: r = 36'sd119537938;
            5'd4: r = 36'sd60000934;   5'd5: r = 36'sd30029717;
            5'd6: r = 36'sd15018523;   5'd7: r = 36'sd7509720;
            5'd8: r = 36'sd3754917;    5'd9: r = 36'sd1877466;
            5'd10: r = 36'sd938734;    5'd11: r = 36'sd469367;
            5'd12: r = 36'sd234684;    5'd13: r = 36'sd117342;
            5'd14: r = 36'sd58671;     5'd15: r = 36'sd29335;
            5'd16: r = 36'sd14668;     5'd17: r = 36'sd7334;
            5'd18: r = 36'sd3667;      5'd19: r = 36'sd1833;
            5'd20: r = 36'sd917;       5'd21: r = 36'sd458;
            5'd22: r = 36'sd229;       5'd23: r = 36'sd115;
            5'd24: r = 36'sd57;        5'd25: r = 36'sd29;
            5'd26: r = 36'sd14;        5'd27: r = 36'sd7;
            5'd28: r = 36'sd4;         5'd29: r = 36'sd2;
            5'd30: r = 36'sd1;
            default: r = '0;
         endcase
         return r;
      end
   endfunction

   // One CORDIC lane: vector (x, y) and residual angle z
   typedef struct packed {
      logic signed [VW-1:0] x;
      logic signed [VW-1:0] y;
      logic signed [AW-1:0] z;
   } lane_type;

endpackage

// ===== rtl/scc_cell.sv =====
// One CORDIC micro-rotation cell for four lanes (two rotating, two vectoring).
// Depends on scc_pkg.
module scc_cell #(
   parameter int STAGE = 0
) (
   input  logic              clock,
   input  logic              advance,
   input  scc_pkg::lane_type rot_in  [2],
   input  scc_pkg::lane_type vec_in  [2],
   output scc_pkg::lane_type rot_out [2],
   output scc_pkg::lane_type vec_out [2]
);
   import scc_pkg::*;

   lane_type rot_ff [2];
   lane_type rot_in_n [2];
   lane_type vec_ff [2];
   lane_type vec_in_n [2];
   localparam logic [4:0] IDX = 5'(STAGE);

   // Rotation lanes steer by the sign of z, vectoring lanes by the sign of y
   always_comb begin
      for (int k = 0; k < 2; k++) begin
         if (!rot_in[k].z[AW-1]) begin
            rot_in_n[k].x = rot_in[k].x - (rot_in[k].y >>> STAGE);
            rot_in_n[k].y = rot_in[k].y + (rot_in[k].x >>> STAGE);
            rot_in_n[k].z = rot_in[k].z - atan_lut(IDX);
         end else begin
            rot_in_n[k].x = rot_in[k].x + (rot_in[k].y >>> STAGE);
            rot_in_n[k].y = rot_in[k].y - (rot_in[k].x >>> STAGE);
            rot_in_n[k].z = rot_in[k].z + atan_lut(IDX);
         end
         if (!vec_in[k].y[VW-1]) begin
            vec_in_n[k].x = vec_in[k].x + (vec_in[k].y >>> STAGE);
            vec_in_n[k].y = vec_in[k].y - (vec_in[k].x >>> STAGE);
            vec_in_n[k].z = vec_in[k].z + atan_lut(IDX);
         end else begin
            vec_in_n[k].x = vec_in[k].x - (vec_in[k].y >>> STAGE);
            vec_in_n[k].y = vec_in[k].y + (vec_in[k].x >>> STAGE);
            vec_in_n[k].z = vec_in[k].z - atan_lut(IDX);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rot_ff <= rot_in_n;
         vec_ff <= vec_in_n;
      end
   end

   assign rot_out = rot_ff;
   assign vec_out = vec_ff;

endmodule

// ===== rtl/scc_isqrt.sv =====
// Pipelined rounding integer square root of a 64-bit value, two result bits per
// stage, then a rounding register. No dependencies.
module scc_isqrt #(
   parameter int TAGW = 1
) (
   input  logic            clock,
   input  logic            advance,
   input  logic [63:0]     op_in,
   input  logic [TAGW-1:0] tag_in,
   output logic [32:0]     root_out,
   output logic [TAGW-1:0] tag_out
);
   localparam int NST = 16;

   // Each stage resolves two root bits: restoring digit recurrence
   logic [63:0]     rem_ff  [NST+1];
   logic [32:0]     r_ff    [NST+1];
   logic [TAGW-1:0] tag_ff  [NST+1];
   logic [32:0]     root_ff;
   logic [TAGW-1:0] tago_ff;

   assign rem_ff[0] = op_in;
   assign r_ff[0]   = '0;
   assign tag_ff[0] = tag_in;

   for (genvar s = 0; s < NST; s++) begin : g_st
      logic [63:0]     rem_q;
      logic [32:0]     r_q;
      logic [TAGW-1:0] t_q;
      logic [65:0]     trial;
      logic [63:0]     rem_in;
      logic [32:0]     r_in;
      // upper bit of the pair first, then the lower one
      always_comb begin
         rem_in = rem_ff[s];
         r_in   = r_ff[s];
         trial  = '0;
         for (int h = 1; h >= 0; h--) begin
            trial = {2'b0, rem_in} -
                    (({33'b0, r_in} << (4*(NST-1-s) + 2*h + 2)) |
                     (66'd1 << (4*(NST-1-s) + 2*h)));
            r_in = r_in << 1;
            if (!trial[65]) begin
               rem_in = trial[63:0];
               r_in   = r_in | 33'd1;
            end
         end
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            rem_q <= rem_in;
            r_q   <= r_in;
            t_q   <= tag_ff[s];
         end
      end
      assign rem_ff[s+1] = rem_q;
      assign r_ff[s+1]   = r_q;
      assign tag_ff[s+1] = t_q;
   end

   // Round to nearest: remainder above root means root + 1
   always_ff @(posedge clock) begin
      if (advance) begin
         root_ff <= r_ff[NST] + 33'((rem_ff[NST] > 64'(r_ff[NST])) ? 1 : 0);
         tago_ff <= tag_ff[NST];
      end
   end

   assign root_out = root_ff;
   assign tag_out  = tago_ff;

endmodule

// ===== rtl/spherical_cartesian_converter.sv =====
// Spherical/cartesian converter, one transaction per cycle sustained.
// Pipeline registers: 1 input register, 17 root pipeline registers (rounding included),
// 1 quadrant-fold register, one per CORDIC cell, 2 product/round.
// The whole pipeline stalls together while rsp_tready is low with a result waiting.
// Reset: synchronous, clears only the valid bits outside the root pipelines; their tags are not reset.
module spherical_cartesian_converter #(
   parameter int ANGLE_ITERATIONS = scc_pkg::ANGLE_ITERATIONS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // in_x, in_y, in_z, in_azimuth, in_elevation, in_distance
   input  logic [175:0] req_tdata,
   input  logic         req_tuser,   // func
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // out_x, out_y, out_z, out_azimuth, out_elevation, out_distance, zero fill
   output logic [183:0] rsp_tdata
);
   import scc_pkg::*;

   localparam int N = (ANGLE_ITERATIONS > TAB_LEN) ? TAB_LEN : ANGLE_ITERATIONS;

   // Whole pipeline moves when output is free (register-type stall)
   logic advance;
   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;

   // Stage A: capture, squares
   logic         va_ff;
   logic         fa_ff;
   logic signed [31:0] xa_ff, ya_ff, za_ff;
   logic signed [24:0] aza_ff;
   logic signed [23:0] ela_ff;
   logic [30:0]  da_ff;
   always_ff @(posedge clock) begin
      if (reset) va_ff <= 1'b0;
      else if (advance) va_ff <= req_tvalid;
      if (advance) begin
         fa_ff  <= req_tuser;
         xa_ff  <= req_tdata[31:0];
         ya_ff  <= req_tdata[63:32];
         za_ff  <= req_tdata[95:64];
         aza_ff <= req_tdata[120:96];
         ela_ff <= req_tdata[144:121];
         da_ff  <= req_tdata[175:145];
      end
   end

   // Normalize: shift count that brings max magnitude to 2^30 or more
   function automatic logic [5:0] norm_sh(input logic [31:0] m);
      logic [5:0] r;
      begin
         r = 6'd0;
         for (int b = 0; b < 31; b++) if (m[b]) r = 6'(30 - b);
         if (m[31]) r = 6'd0;
         return r;
      end
   endfunction
   function automatic logic [31:0] magn(input logic signed [31:0] v);
      return v[31] ? 32'(-v) : 32'(v);
   endfunction

   logic [31:0] mx, my, mz, mxy, mxyz;
   logic [5:0]  sh_xy, sh_xyz;
   logic signed [32:0] xs, ys, zs;   // normalized, magnitude at most 2^31
   logic [63:0] sum3, sumxy;
   always_comb begin
      mx = magn(xa_ff); my = magn(ya_ff); mz = magn(za_ff);
      mxy  = (mx > my) ? mx : my;
      mxyz = (mxy > mz) ? mxy : mz;
      sh_xy  = norm_sh(mxy);
      sh_xyz = norm_sh(mxyz);
      sum3 = 64'(64'(xa_ff) * 64'(xa_ff)) + 64'(64'(ya_ff) * 64'(ya_ff))
           + 64'(64'(za_ff) * 64'(za_ff));
      xs = 33'(64'(xa_ff) <<< sh_xyz);
      ys = 33'(64'(ya_ff) <<< sh_xyz);
      zs = 33'(64'(za_ff) <<< sh_xyz);
      sumxy = 64'(xs * xs) + 64'(ys * ys);
   end

   // Payload carried alongside the root pipelines
   typedef struct packed {
      logic               v;
      logic               f;
      logic signed [35:0] ax;   // azimuth vector a = y (normalized)
      logic signed [35:0] ay;   // b = -x
      logic signed [35:0] zn;   // normalized z
      logic               axis;
      logic               zero;
      logic               zpos;
      logic signed [24:0] az;
      logic signed [23:0] el;
      logic [30:0]        d;
   } carry_type;

   carry_type ca;
   always_comb begin
      ca.v = va_ff; ca.f = fa_ff;
      ca.ax = 36'(64'(ya_ff) <<< sh_xy);
      ca.ay = 36'(-(64'(xa_ff) <<< sh_xy));
      ca.zn = 36'(zs);
      ca.axis = (xa_ff == 0) && (ya_ff == 0);
      ca.zero = ca.axis && (za_ff == 0);
      ca.zpos = !za_ff[31];
      ca.az = aza_ff; ca.el = ela_ff; ca.d = da_ff;
   end

   logic [32:0] dist_r, hor_r;
   carry_type   cs;
   logic [$bits(carry_type)-1:0] cs_bits;
   logic        hor_v;
   scc_isqrt #(.TAGW($bits(carry_type))) u_dist (
      .clock(clock), .advance(advance), .op_in(sum3), .tag_in(ca),
      .root_out(dist_r), .tag_out(cs_bits));
   scc_isqrt #(.TAGW(1)) u_hor (
      .clock(clock), .advance(advance), .op_in(sumxy), .tag_in(va_ff),
      .root_out(hor_r), .tag_out(hor_v));
   assign cs = carry_type'(cs_bits);

   // Prep: quadrant fold for vectoring and rotation lanes
   function automatic lane_type vfold(input logic signed [35:0] a,
                                      input logic signed [35:0] b);
      lane_type l;
      begin
         l.x = a; l.y = b; l.z = '0;
         if (a[35]) begin
            if (!b[35]) begin l.x = b; l.y = -a; l.z = DEG90; end
            else begin l.x = -b; l.y = a; l.z = -DEG90; end
         end
         return l;
      end
   endfunction
   function automatic lane_type rfold(input logic signed [AW-1:0] ang,
                                      output logic neg);
      lane_type l;
      logic signed [AW-1:0] z;
      begin
         z = ang; neg = 1'b0;
         if (z > DEG180) z = z - DEG360;
         else if (z <= -DEG180) z = z + DEG360;
         if (z > DEG90) begin z = z - DEG180; neg = 1'b1; end
         else if (z < -DEG90) begin z = z + DEG180; neg = 1'b1; end
         l.x = GAIN_Q30; l.y = '0; l.z = z;
         return l;
      end
   endfunction

   lane_type rot0 [2], vec0 [2];
   logic     neg_a, neg_e;
   always_comb begin
      vec0[0] = vfold(cs.ax, cs.ay);
      vec0[1] = vfold(36'(hor_r), cs.zn);
      rot0[0] = rfold(AW'(cs.az) <<< 8, neg_a);
      rot0[1] = rfold(AW'(cs.el) <<< 8, neg_e);
   end

   // Carry metadata through the chain
   logic       vb_ff [N+1];
   carry_type  cb_ff [N+1];
   logic [32:0] db_ff [N+1];
   logic [1:0] nb_ff [N+1];
   lane_type   rot_c [N+1][2];
   lane_type   vec_c [N+1][2];
   lane_type   rot_ff0 [2], vec_ff0 [2];

   always_ff @(posedge clock) begin
      if (reset) vb_ff[0] <= 1'b0;
      else if (advance) vb_ff[0] <= cs.v && hor_v;
      if (advance) begin
         cb_ff[0] <= cs; db_ff[0] <= dist_r; nb_ff[0] <= {neg_e, neg_a};
         rot_ff0 <= rot0; vec_ff0 <= vec0;
      end
   end
   assign rot_c[0] = rot_ff0;
   assign vec_c[0] = vec_ff0;

   for (genvar i = 0; i < N; i++) begin : g_cell
      scc_cell #(.STAGE(i)) u_cell (
         .clock(clock), .advance(advance),
         .rot_in(rot_c[i]), .vec_in(vec_c[i]),
         .rot_out(rot_c[i+1]), .vec_out(vec_c[i+1]));
      always_ff @(posedge clock) begin
         if (reset) vb_ff[i+1] <= 1'b0;
         else if (advance) vb_ff[i+1] <= vb_ff[i];
         if (advance) begin
            cb_ff[i+1] <= cb_ff[i]; db_ff[i+1] <= db_ff[i]; nb_ff[i+1] <= nb_ff[i];
         end
      end
   end

   // Post 1: trig products ca*ce, sa*ce, rounded Q30; angles registered
   function automatic logic signed [35:0] rq30(input logic signed [71:0] p);
      logic signed [71:0] t;
      begin
         t = (p + 72'sd536870912) >>> 30;
         return 36'(t);
      end
   endfunction

   logic signed [35:0] cA, sA, cE, sE;
   always_comb begin
      cA = nb_ff[N][0] ? -rot_c[N][0].x : rot_c[N][0].x;
      sA = nb_ff[N][0] ? -rot_c[N][0].y : rot_c[N][0].y;
      cE = nb_ff[N][1] ? -rot_c[N][1].x : rot_c[N][1].x;
      sE = nb_ff[N][1] ? -rot_c[N][1].y : rot_c[N][1].y;
   end

   logic        vp_ff;
   carry_type   cp_ff;
   logic [32:0] dp_ff;
   logic signed [35:0] sace_ff, cace_ff, se_ff;
   logic signed [AW-1:0] azacc_ff, elacc_ff;
   always_ff @(posedge clock) begin
      if (reset) vp_ff <= 1'b0;
      else if (advance) vp_ff <= vb_ff[N];
      if (advance) begin
         cp_ff <= cb_ff[N]; dp_ff <= db_ff[N];
         sace_ff <= rq30(72'(sA) * 72'(cE));
         cace_ff <= rq30(72'(cA) * 72'(cE));
         se_ff   <= sE;
         azacc_ff <= vec_c[N][0].z;
         elacc_ff <= vec_c[N][1].z;
      end
   end

   // Post 2: multiply by distance, round, saturate; finish angles
   function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
      if (v > 72'sd2147483647) return 32'sh7FFFFFFF;
      if (v < -72'sd2147483648) return 32'sh80000000;
      return 32'(v);
   endfunction
   function automatic logic signed [AW-1:0] rang(input logic signed [AW-1:0] a);
      return (a + AW'(128)) >>> 8;
   endfunction

   logic signed [71:0] dm, px, py, pz;
   logic signed [AW-1:0] azr, elr;
   logic signed [24:0] az_o;
   logic signed [23:0] el_o;
   logic [31:0] d_o;
   logic [183:0] data_n;
   always_comb begin
      // distance is unsigned; zero-extended, then used as a signed operand
      dm = $signed(72'(cp_ff.d));
      px = -((72'(sace_ff) * dm + 72'sd536870912) >>> 30);
      py = (72'(cace_ff) * dm + 72'sd536870912) >>> 30;
      pz = (72'(se_ff) * dm + 72'sd536870912) >>> 30;
      azr = rang(azacc_ff);
      elr = rang(elacc_ff);
      az_o = (azr > AW'(AZ_MAX)) ? AZ_MAX : (azr < -AW'(AZ_MAX)) ? -AZ_MAX : 25'(azr);
      el_o = (elr > AW'(EL_MAX)) ? EL_MAX : (elr < -AW'(EL_MAX)) ? -EL_MAX : 24'(elr);
      d_o  = dp_ff[32] ? 32'hFFFFFFFF : dp_ff[31:0];
      data_n = '0;
      if (cp_ff.f) begin
         data_n[31:0]  = sat32(px);
         data_n[63:32] = sat32(py);
         data_n[95:64] = sat32(pz);
      end else if (!cp_ff.zero) begin
         data_n[176:145] = d_o;
         if (cp_ff.axis) begin
            data_n[144:121] = cp_ff.zpos ? EL_MAX : -EL_MAX;
         end else begin
            data_n[120:96]  = az_o;
            data_n[144:121] = el_o;
         end
      end
   end

   logic         vo_ff;
   logic [183:0] do_ff;
   always_ff @(posedge clock) begin
      if (reset) vo_ff <= 1'b0;
      else if (advance) vo_ff <= vp_ff;
      if (advance) do_ff <= data_n;
   end

   assign rsp_tvalid = vo_ff;
   assign rsp_tdata  = do_ff;

endmodule
